@@ sv/imgconv_pkg.sv @@
package imgconv_pkg;

    // Geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int W_W        = COL_W + 1;
    localparam int GEOM_W     = 11;
    localparam int INROW_W    = GEOM_W + 1;

    // Datapath widths
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int KDIM       = 3;
    localparam int ROWCOEF_W  = KDIM * COEF_W;
    localparam int PROD_W     = 24;
    localparam int COLSUM_W   = 26;
    localparam int SUM_W      = 28;

    // Register port
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int IDX_W      = ADDR_W - 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_KERNEL_RADIUS = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_TOP      = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_MIDDLE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF_BOTTOM   = 3'd5;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_value;
    } pix_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic                    frame_last;
    } res_item_t;

    // Per-cycle controls shared by all window cells
    typedef struct packed {
        logic shift;
        logic clear;
        logic mul_en;
        logic sum_en;
    } cell_ctrl_t;

endpackage

@@ sv/imgconv_line_store.sv @@
module imgconv_line_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [imgconv_pkg::COL_W-1:0] addr,
    input  imgconv_pkg::pix_t            wr_pix,
    output imgconv_pkg::pix_t            above1,
    output imgconv_pkg::pix_t            above2
);
    import imgconv_pkg::*;

    pix_t lower_mem [MAX_WIDTH];
    pix_t upper_mem [MAX_WIDTH];

    pix_t             rd_lower_reg;
    pix_t             rd_upper_reg;
    pix_t             byp_data_reg;
    logic             byp_hit_reg;
    logic             pend_valid_reg;
    logic [COL_W-1:0] pend_addr_reg;

    // Lower store: new pixel written, old value read at the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lower_mem[addr] <= wr_pix;
            rd_lower_reg    <= lower_mem[addr];
        end
    end

    // Upper store: read now, takes the row pushed out of the lower store in the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg <= upper_mem[addr];
            byp_data_reg <= rd_lower_reg;
        end
        if (pend_valid_reg)
        begin
            upper_mem[pend_addr_reg] <= rd_lower_reg;
        end
    end

    // Pending write tracking and read-after-write bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
            byp_hit_reg    <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= rd_en;
            if (rd_en)
            begin
                pend_addr_reg <= addr;
                byp_hit_reg   <= pend_valid_reg && (pend_addr_reg == addr);
            end
        end
    end

    assign above1 = rd_lower_reg;
    assign above2 = byp_hit_reg ? byp_data_reg : rd_upper_reg;

endmodule

@@ sv/imgconv_cell.sv @@
module imgconv_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  imgconv_pkg::cell_ctrl_t               ctrl,
    input  imgconv_pkg::pix_t  [imgconv_pkg::KDIM-1:0] pix_in,
    input  imgconv_pkg::coef_t [imgconv_pkg::KDIM-1:0] coef,
    input  logic               [imgconv_pkg::KDIM-1:0] tap_en,
    output imgconv_pkg::pix_t  [imgconv_pkg::KDIM-1:0] pix_out,
    output logic signed [imgconv_pkg::COLSUM_W-1:0]    col_sum
);
    import imgconv_pkg::*;

    pix_t [KDIM-1:0]              pix_reg;
    pix_t [KDIM-1:0]              pix_next;
    logic signed [PROD_W-1:0]     prod_reg [KDIM];
    logic signed [PROD_W-1:0]     prod_next [KDIM];
    logic signed [PROD_W:0]       prod_full [KDIM];
    logic signed [COLSUM_W-1:0]   col_sum_reg;
    logic signed [COLSUM_W-1:0]   col_sum_next;

    // Window column: load from neighbor on shift, zero on frame restart
    always_comb
    begin
        if (ctrl.shift)
        begin
            pix_next = pix_in;
        end
        else if (ctrl.clear)
        begin
            pix_next = '0;
        end
        else
        begin
            pix_next = pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else
        begin
            pix_reg <= pix_next;
        end
    end

    // Three masked taps of this column
    always_comb
    begin
        for (int r = 0; r < KDIM; r++)
        begin
            prod_full[r] = coef[r] * $signed({1'b0, pix_reg[r]});
            prod_next[r] = tap_en[r] ? prod_full[r][PROD_W-1:0] : '0;
        end
    end

    always_comb
    begin
        col_sum_next = COLSUM_W'(prod_reg[0]) + COLSUM_W'(prod_reg[1])
                     + COLSUM_W'(prod_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.sum_en)
        begin
            col_sum_reg <= col_sum_next;
        end
    end

    assign pix_out = pix_reg;
    assign col_sum = col_sum_reg;

endmodule

@@ sv/image_convolution_3x3_zero_pad.sv @@
// Streams 8-bit pixels in raster order and returns one signed 28-bit
// convolution sum per pixel, with taps outside the frame counted as zero.
// One transfer is taken every clock; a stalled result stalls the input in the
// same cycle. After the transfer that releases it, a result passes through:
// line store read, window shift, tap products, column sums, final add. With a
// 3x3 kernel the results lag the input by frame_width+1 items, so after the
// last pixel frame_width+1 drain items (kind = 1) release the remaining sums;
// the last one carries frame_last. With a 1x1 kernel each pixel gives its
// result directly. The row stores come up uninitialized and need no clearing
// pass. Writing frame_width, frame_height or kernel_radius restarts the frame;
// coefficient writes act at once. Registers sit at byte address 8*index.
module image_convolution_3x3_zero_pad (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  imgconv_pkg::pix_item_t            pix_item,
    output logic                              res_valid,
    input  logic                              res_stall,
    output imgconv_pkg::res_item_t            res_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imgconv_pkg::ADDR_W-1:0]    paddr,
    input  logic [imgconv_pkg::DATA_W-1:0]    pwdata,
    output logic [imgconv_pkg::DATA_W-1:0]    prdata,
    output logic                              pready
);
    import imgconv_pkg::*;

    // Configuration registers
    logic [GEOM_W-1:0]    frame_width_reg;
    logic [GEOM_W-1:0]    frame_height_reg;
    logic                 kernel_radius_reg;
    logic [ROWCOEF_W-1:0] coef_top_reg;
    logic [ROWCOEF_W-1:0] coef_mid_reg;
    logic [ROWCOEF_W-1:0] coef_bot_reg;
    logic [IDX_W-1:0]     reg_idx;
    logic                 cfg_wr;
    logic                 restart;

    // Frame position
    logic [COL_W-1:0]     in_column_reg, in_column_next;
    logic [INROW_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]     out_column_reg, out_column_next;
    logic [GEOM_W-1:0]    out_row_reg, out_row_next;

    logic [W_W-1:0]       w_eff;
    logic [GEOM_W-1:0]    h_eff;
    logic                 big;
    logic                 advance;
    logic                 accept;
    logic                 in_done;
    logic                 real_pix;
    logic                 act;
    logic                 early;
    logic                 emit;
    logic                 last;
    logic [W_W-1:0]       col_inc;
    logic [INROW_W-1:0]   row_inc;
    logic [W_W-1:0]       oc_inc;
    logic [GEOM_W:0]      or_inc;
    pix_t                 new_pix;
    logic [KDIM-1:0]      row_en;
    logic [KDIM-1:0]      col_en;
    logic [KDIM-1:0][KDIM-1:0] mask_next;

    // Pipeline stages
    logic                       b_valid_reg, b_emit_reg, b_last_reg;
    logic [KDIM-1:0][KDIM-1:0]  b_mask_reg;
    pix_t                       b_pix_reg;
    logic                       c_valid_reg, c_last_reg;
    logic [KDIM-1:0][KDIM-1:0]  c_mask_reg;
    logic                       d_valid_reg, d_last_reg;
    logic                       e_valid_reg, e_last_reg;
    logic                       res_valid_reg;
    res_item_t                  res_item_reg;

    // Window cells
    cell_ctrl_t                      cell_ctrl;
    pix_t  [KDIM-1:0][KDIM-1:0]      cell_in;
    pix_t  [KDIM-1:0][KDIM-1:0]      cell_out;
    coef_t [KDIM-1:0][KDIM-1:0]      cell_coef;
    logic signed [COLSUM_W-1:0]      col_sum [KDIM];
    logic signed [SUM_W-1:0]         total;
    pix_t                            above1;
    pix_t                            above2;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign restart = cfg_wr && ((reg_idx == REG_FRAME_WIDTH)
                                || (reg_idx == REG_FRAME_HEIGHT)
                                || (reg_idx == REG_KERNEL_RADIUS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= GEOM_W'(1);
            frame_height_reg  <= GEOM_W'(1);
            kernel_radius_reg <= 1'b1;
            coef_top_reg      <= '0;
            coef_mid_reg      <= ROWCOEF_W'(65536);
            coef_bot_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_FRAME_WIDTH:   frame_width_reg   <= pwdata[GEOM_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[GEOM_W-1:0];
                REG_KERNEL_RADIUS: kernel_radius_reg <= pwdata[0];
                REG_COEF_TOP:      coef_top_reg      <= pwdata[ROWCOEF_W-1:0];
                REG_COEF_MIDDLE:   coef_mid_reg      <= pwdata[ROWCOEF_W-1:0];
                REG_COEF_BOTTOM:   coef_bot_reg      <= pwdata[ROWCOEF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:   prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:  prdata = DATA_W'(frame_height_reg);
            REG_KERNEL_RADIUS: prdata = DATA_W'(kernel_radius_reg);
            REG_COEF_TOP:      prdata = DATA_W'(coef_top_reg);
            REG_COEF_MIDDLE:   prdata = DATA_W'(coef_mid_reg);
            REG_COEF_BOTTOM:   prdata = DATA_W'(coef_bot_reg);
            default:           prdata = '0;
        endcase
    end

    // Effective geometry
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_W'(frame_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? GEOM_W'(1) : frame_height_reg;
        big   = kernel_radius_reg && (MAX_KERNEL >= 3);
    end

    // Handshake
    assign advance   = !(res_valid_reg && res_stall);
    assign pix_stall = !advance;
    assign accept    = pix_valid && advance;

    // Input side decode
    always_comb
    begin
        in_done  = in_row_reg >= INROW_W'(h_eff);
        real_pix = !pix_item.kind && !in_done;
        act      = real_pix || in_done;
        new_pix  = real_pix ? pix_item.pixel_value : '0;
        early    = big && ((in_row_reg == '0)
                           || ((in_row_reg == INROW_W'(1)) && (in_column_reg == '0)));
        emit     = act && !early;
        col_inc  = W_W'(in_column_reg) + W_W'(1);
        row_inc  = in_row_reg + INROW_W'(1);
        oc_inc   = W_W'(out_column_reg) + W_W'(1);
        or_inc   = {1'b0, out_row_reg} + (GEOM_W+1)'(1);
        last     = (or_inc >= {1'b0, h_eff}) && (oc_inc >= w_eff);
    end

    // Which taps lie inside the frame for the output being released
    always_comb
    begin
        row_en[0] = out_row_reg != '0;
        row_en[1] = 1'b1;
        row_en[2] = !(or_inc >= {1'b0, h_eff});
        col_en[0] = out_column_reg != '0;
        col_en[1] = 1'b1;
        col_en[2] = !(oc_inc >= w_eff);
        mask_next = '0;
        if (big)
        begin
            for (int c = 0; c < KDIM; c++)
            begin
                for (int r = 0; r < KDIM; r++)
                begin
                    mask_next[c][r] = col_en[c] && row_en[r];
                end
            end
        end
        else
        begin
            mask_next[KDIM-1][KDIM-1] = 1'b1;
        end
    end

    // Frame position counters
    always_comb
    begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        if (restart)
        begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
        end
        else if (accept && act)
        begin
            if (col_inc >= w_eff)
            begin
                in_column_next = '0;
                in_row_next    = row_inc;
            end
            else
            begin
                in_column_next = col_inc[COL_W-1:0];
            end
            if (emit)
            begin
                if (last)
                begin
                    in_column_next  = '0;
                    in_row_next     = '0;
                    out_column_next = '0;
                    out_row_next    = '0;
                end
                else if (oc_inc >= w_eff)
                begin
                    out_column_next = '0;
                    out_row_next    = or_inc[GEOM_W-1:0];
                end
                else
                begin
                    out_column_next = oc_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

    // Two row stores behind the window
    imgconv_line_store u_line_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept && act),
        .addr   (in_column_reg),
        .wr_pix (new_pix),
        .above1 (above1),
        .above2 (above2)
    );

    // Pipeline valid and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            b_emit_reg    <= 1'b0;
            b_last_reg    <= 1'b0;
            c_valid_reg   <= 1'b0;
            c_last_reg    <= 1'b0;
            d_valid_reg   <= 1'b0;
            d_last_reg    <= 1'b0;
            e_valid_reg   <= 1'b0;
            e_last_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg   <= accept && act;
            b_emit_reg    <= emit;
            b_last_reg    <= last;
            c_valid_reg   <= b_valid_reg && b_emit_reg;
            c_last_reg    <= b_last_reg;
            d_valid_reg   <= c_valid_reg;
            d_last_reg    <= c_last_reg;
            e_valid_reg   <= d_valid_reg;
            e_last_reg    <= d_last_reg;
            res_valid_reg <= e_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_pix_reg    <= new_pix;
            b_mask_reg   <= mask_next;
            c_mask_reg   <= b_mask_reg;
            res_item_reg <= '{conv_sum: total, frame_last: e_last_reg};
        end
    end

    // Cell controls and neighbor chaining
    always_comb
    begin
        cell_ctrl.shift  = advance && b_valid_reg;
        cell_ctrl.clear  = restart || (advance && c_valid_reg && c_last_reg);
        cell_ctrl.mul_en = advance;
        cell_ctrl.sum_en = advance;
        cell_in[KDIM-1][0] = above2;
        cell_in[KDIM-1][1] = above1;
        cell_in[KDIM-1][2] = b_pix_reg;
        for (int c = 0; c < KDIM - 1; c++)
        begin
            cell_in[c] = cell_ctrl.clear ? '0 : cell_out[c+1];
        end
    end

    // Coefficients by column and row
    always_comb
    begin
        for (int c = 0; c < KDIM; c++)
        begin
            cell_coef[c][0] = coef_top_reg[c*COEF_W +: COEF_W];
            cell_coef[c][1] = coef_mid_reg[c*COEF_W +: COEF_W];
            cell_coef[c][2] = coef_bot_reg[c*COEF_W +: COEF_W];
        end
        // 1x1 kernel: centre coefficient applied to the newest pixel
        if (!big)
        begin
            cell_coef[KDIM-1][KDIM-1] = coef_mid_reg[COEF_W +: COEF_W];
        end
    end

    for (genvar c = 0; c < KDIM; c++)
    begin : g_cell
        imgconv_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .pix_in  (cell_in[c]),
            .coef    (cell_coef[c]),
            .tap_en  (c_mask_reg[c]),
            .pix_out (cell_out[c]),
            .col_sum (col_sum[c])
        );
    end

    // Final add of the three column sums
    assign total = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

@@ sv/imgconv_checker.sv @@
module imgconv_assertions (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pix_stall,
    input logic                           res_valid,
    input logic                           res_stall,
    input imgconv_pkg::res_item_t         res_item,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [imgconv_pkg::ADDR_W-1:0] paddr,
    input logic [imgconv_pkg::DATA_W-1:0] pwdata,
    input logic [imgconv_pkg::DATA_W-1:0] prdata
);
    import imgconv_pkg::*;

    // Held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // Input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid && res_stall)
        else $error("input stalled without a stalled result");

    // Kernel radius reads back a single bit
    a_radius_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[ADDR_W-1:3] == REG_KERNEL_RADIUS)
        |-> prdata[DATA_W-1:1] == '0)
        else $error("kernel radius readback too wide");

    // Top coefficient row reads back what was written
    a_coef_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[ADDR_W-1:3] == REG_COEF_TOP)
        |=> !psel || pwrite || (paddr[ADDR_W-1:3] != REG_COEF_TOP)
            || (prdata == DATA_W'($past(pwdata[ROWCOEF_W-1:0]))))
        else $error("coefficient readback mismatch");

endmodule

bind image_convolution_3x3_zero_pad imgconv_assertions u_imgconv_assertions (.*);

@@ test/imgconv_checker.sv @@
// Watches the pixel, result and register channels of the convolution block.
// Keeps its own copy of the register settings, line stores and window, works
// out the sum owed for each pixel transfer, and compares every result transfer
// against the oldest sum still owed.
module imgconv_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    input  logic                           pix_stall,
    input  imgconv_pkg::pix_item_t         pix_item,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  imgconv_pkg::res_item_t         res_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [imgconv_pkg::ADDR_W-1:0] paddr,
    input  logic [imgconv_pkg::DATA_W-1:0] pwdata,
    output int                             fail_count,
    output int unsigned                    sums_due
);
    import imgconv_pkg::*;

    // Register copies
    logic [GEOM_W-1:0]    cfg_width;
    logic [GEOM_W-1:0]    cfg_height;
    logic                 cfg_radius;
    logic [ROWCOEF_W-1:0] cfg_coef [3];

    // Line stores: one row up and two rows up
    logic [PIX_W-1:0] line_above  [MAX_WIDTH];
    logic [PIX_W-1:0] line_above2 [MAX_WIDTH];

    // 3x3 window, row-major, top row first
    logic [PIX_W-1:0] window_pix [9];

    int unsigned in_col, in_row, out_col, out_row;

    res_item_t owed_sums [$];

    function automatic coef_t tap_weight(input int unsigned row, input int unsigned col);
        return coef_t'(cfg_coef[row][COEF_W*col +: COEF_W]);
    endfunction

    task automatic rewind_frame();
        for (int k = 0; k < 9; k++)
        begin
            window_pix[k] = '0;
        end
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    // Advance the window by one transfer and queue the sum it releases, if any
    task automatic convolve_pixel(input pix_item_t it);
        int unsigned w, h, lag, idx;
        bit big, done, is_pixel, last_px;
        logic [PIX_W-1:0] p, up1, up2;
        longint acc;
        res_item_t sum_item;

        w = cfg_width;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = cfg_height;
        if (h < 1) h = 1;
        big = cfg_radius && (MAX_KERNEL >= 3);
        lag = big ? w + 1 : 0;

        done     = (in_row >= h);
        is_pixel = !it.kind && !done;
        // drain mid-frame, or with nothing left to release
        if (!is_pixel && !done) return;

        p   = is_pixel ? it.pixel_value : '0;
        up2 = line_above2[in_col];
        up1 = line_above[in_col];
        for (int r = 0; r < 3; r++)
        begin
            window_pix[r*3]   = window_pix[r*3+1];
            window_pix[r*3+1] = window_pix[r*3+2];
        end
        window_pix[2] = up2;
        window_pix[5] = up1;
        window_pix[8] = p;
        line_above2[in_col] = up1;
        line_above[in_col]  = p;

        idx = in_row * w + in_col;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (idx < lag) return;

        acc = 0;
        if (!big)
        begin
            acc = longint'(tap_weight(1, 1)) * longint'(p);
        end
        else
        begin
            for (int r = 0; r < 3; r++)
            begin
                // rows above the top or below the bottom edge are zero
                if (r == 0 && out_row == 0) continue;
                if (r == 2 && out_row + 1 >= h) continue;
                for (int c = 0; c < 3; c++)
                begin
                    if (c == 0 && out_col == 0) continue;
                    if (c == 2 && out_col + 1 >= w) continue;
                    acc += longint'(tap_weight(r, c)) * longint'(window_pix[r*3+c]);
                end
            end
        end

        last_px = (out_row + 1 >= h) && (out_col + 1 >= w);
        sum_item.conv_sum   = acc[SUM_W-1:0];
        sum_item.frame_last = last_px;
        owed_sums.push_back(sum_item);

        if (last_px)
        begin
            rewind_frame();
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_item_t want;
        if (!rst_n)
        begin
            cfg_width   = 1;
            cfg_height  = 1;
            cfg_radius  = 1'b1;
            cfg_coef[0] = '0;
            cfg_coef[1] = ROWCOEF_W'(65536);
            cfg_coef[2] = '0;
            for (int k = 0; k < MAX_WIDTH; k++)
            begin
                line_above[k]  = '0;
                line_above2[k] = '0;
            end
            rewind_frame();
            owed_sums.delete();
            fail_count = 0;
            sums_due  <= 0;
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:3])
                    REG_FRAME_WIDTH:
                    begin
                        cfg_width = pwdata[GEOM_W-1:0];
                        rewind_frame();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        cfg_height = pwdata[GEOM_W-1:0];
                        rewind_frame();
                    end
                    REG_KERNEL_RADIUS:
                    begin
                        cfg_radius = pwdata[0];
                        rewind_frame();
                    end
                    REG_COEF_TOP:    cfg_coef[0] = pwdata[ROWCOEF_W-1:0];
                    REG_COEF_MIDDLE: cfg_coef[1] = pwdata[ROWCOEF_W-1:0];
                    REG_COEF_BOTTOM: cfg_coef[2] = pwdata[ROWCOEF_W-1:0];
                    default: ;
                endcase
            end

            // pixel transfer
            if (pix_valid && !pix_stall)
            begin
                convolve_pixel(pix_item);
            end

            // result transfer
            if (res_valid && !res_stall)
            begin
                if (owed_sums.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %0d frame_last %0b",
                             $time, "actual conv_sum", res_item.conv_sum,
                             res_item.frame_last);
                    fail_count++;
                end
                else
                begin
                    want = owed_sums.pop_front();
                    if (res_item.conv_sum !== want.conv_sum)
                    begin
                        $display("%0t: conv_sum expected %0d actual %0d",
                                 $time, want.conv_sum, res_item.conv_sum);
                        fail_count++;
                    end
                    if (res_item.frame_last !== want.frame_last)
                    begin
                        $display("%0t: frame_last expected %0b actual %0b",
                                 $time, want.frame_last, res_item.frame_last);
                        fail_count++;
                    end
                end
            end

            sums_due <= owed_sums.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
module tb_top ();
    import imgconv_pkg::*;

    localparam logic        KIND_PIXEL    = 1'b0;
    localparam logic        KIND_DRAIN    = 1'b1;
    localparam int unsigned RANDOM_ITEMS  = 1850;
    localparam int unsigned IDLE_LONGEST  = 14;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              pix_valid;
    logic              pix_stall;
    pix_item_t         pix_item;
    logic              res_valid;
    logic              res_stall;
    res_item_t         res_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int unsigned       sums_due;

    // longest idle draw for both sides; zero gives back-to-back stretches
    int unsigned idle_max = IDLE_LONGEST;
    int unsigned random_sent = 0;

    // effective geometry, used only to shape frames
    int unsigned cur_w, cur_h;
    logic        cur_r;

    image_convolution_3x3_zero_pad dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    imgconv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_item   (pix_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .sums_due   (sums_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Random bits above the register's width; the block must ignore them
    function automatic logic [DATA_W-1:0] pad_noise(input logic [DATA_W-1:0] v,
                                                    input int unsigned bits);
        logic [DATA_W-1:0] noise;
        noise = {$urandom, $urandom};
        return (noise << bits) | v;
    endfunction

    // Setup cycle, then access cycle; the write lands when pready is seen
    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One pixel-channel transfer after a random gap
    task automatic push_pixel(input logic is_drain, input logic [PIX_W-1:0] value);
        int unsigned gap;
        gap = $urandom_range(idle_max, 0);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item  <= '{kind: is_drain, pixel_value: value};
        @(posedge clk);
        while (pix_stall) @(posedge clk);
    endtask

    // Wait until every owed sum is back and the pipeline has emptied
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (sums_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame in raster order, then the drains that flush it
    task automatic run_frame(input bit cut_short);
        int unsigned total, stop_at;
        logic [PIX_W-1:0] px;
        total   = cur_w * cur_h;
        stop_at = cut_short ? $urandom_range(total - 1, 0) : total;
        for (int unsigned k = 0; k < stop_at; k++)
        begin
            // stray drain mid-frame, ignored
            if ($urandom_range(19, 0) == 0) push_pixel(KIND_DRAIN, PIX_W'($urandom));
            if ($urandom_range(7, 0) == 0)
                px = {PIX_W{1'($urandom_range(1, 0))}};
            else
                px = PIX_W'($urandom);
            push_pixel(KIND_PIXEL, px);
            random_sent++;
        end
        if (cut_short) return;
        // lagging sums; a pixel here acts as a drain
        if (cur_r)
        begin
            repeat (cur_w + 1)
            begin
                push_pixel(1'($urandom_range(1, 0)), PIX_W'($urandom));
                random_sent++;
            end
        end
        // drains with nothing pending
        if ($urandom_range(3, 0) == 0)
        begin
            repeat ($urandom_range(3, 1)) push_pixel(KIND_DRAIN, PIX_W'($urandom));
        end
    endtask

    // Receiver: random stall before each result transfer
    initial
    begin : result_sink
        int unsigned hold;
        res_stall <= 1'b0;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever
        begin
            hold = $urandom_range(idle_max, 0);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [GEOM_W-1:0]    w_raw;
        logic [GEOM_W-1:0]    h_raw;
        logic [ROWCOEF_W-1:0] taps_row;
        logic [IDX_W-1:0]     coef_reg;
        int unsigned          frames, phase_no;
        bit                   cut, wide_phase;

        pix_valid <= 1'b0;
        pix_item  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 1x1 frame, 3x3 kernel, centre tap 1
        push_pixel(KIND_DRAIN, 8'hAA);   // before any pixel: ignored
        push_pixel(KIND_PIXEL, 8'hFF);
        push_pixel(KIND_PIXEL, 8'h11);   // frame already full: acts as drain
        push_pixel(KIND_DRAIN, 8'h00);
        push_pixel(KIND_DRAIN, 8'h55);   // nothing pending: ignored
        push_pixel(KIND_PIXEL, 8'h00);
        push_pixel(KIND_DRAIN, 8'h00);
        push_pixel(KIND_DRAIN, 8'h00);
        settle();

        // Most negative sums: every tap at its minimum on a saturated 3x3 frame
        reg_write(REG_FRAME_WIDTH, 64'd3);
        reg_write(REG_FRAME_HEIGHT, 64'd3);
        reg_write(REG_COEF_TOP, 64'h8000_8000_8000);
        reg_write(REG_COEF_MIDDLE, 64'h8000_8000_8000);
        reg_write(REG_COEF_BOTTOM, 64'h8000_8000_8000);
        repeat (9) push_pixel(KIND_PIXEL, 8'hFF);
        repeat (4) push_pixel(KIND_DRAIN, 8'hFF);
        settle();

        // 1x1 kernel, largest centre tap, single row, no lag
        reg_write(REG_KERNEL_RADIUS, 64'd0);
        reg_write(REG_FRAME_HEIGHT, 64'd1);
        reg_write(REG_COEF_MIDDLE, 64'h0000_7FFF_0000);
        push_pixel(KIND_PIXEL, 8'hFF);
        push_pixel(KIND_PIXEL, 8'h00);
        push_pixel(KIND_PIXEL, 8'h80);
        settle();
        h_raw = 1;
        cur_r = 1'b0;

        // Random phases; two of them stretch the geometry
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            idle_max   = ($urandom_range(3, 0) == 0) ? 0 : IDLE_LONGEST;
            frames     = $urandom_range(3, 1);
            cut        = ($urandom_range(7, 0) == 0);
            wide_phase = (phase_no == 2) || (phase_no == 3);
            if (wide_phase)
            begin
                // one full-width row (clamped) under a 1x1 kernel, or a tall single column
                w_raw  = (phase_no == 2) ? '1 : '0;
                h_raw  = (phase_no == 2) ? GEOM_W'(1) : GEOM_W'(256);
                cur_r  = (phase_no == 2) ? 1'b0 : 1'b1;
                frames = 1;
                cut    = 1'b0;
                reg_write(REG_FRAME_HEIGHT, pad_noise(DATA_W'(h_raw), GEOM_W));
                reg_write(REG_KERNEL_RADIUS, pad_noise(DATA_W'(cur_r), 1));
            end
            else
            begin
                w_raw = ($urandom_range(15, 0) == 0) ? '0 : GEOM_W'($urandom_range(12, 1));
                if ($urandom_range(3, 0) != 0)
                begin
                    h_raw = ($urandom_range(15, 0) == 0) ? '0 : GEOM_W'($urandom_range(8, 1));
                    reg_write(REG_FRAME_HEIGHT, pad_noise(DATA_W'(h_raw), GEOM_W));
                end
                if ($urandom_range(3, 0) != 0)
                begin
                    cur_r = 1'($urandom_range(1, 0));
                    reg_write(REG_KERNEL_RADIUS, pad_noise(DATA_W'(cur_r), 1));
                end
            end

            // coefficient rows, some left as they were
            for (int i = 0; i < 3; i++)
            begin
                if ($urandom_range(1, 0) == 1)
                begin
                    case ($urandom_range(7, 0))
                        0:       taps_row = 48'h7FFF_7FFF_7FFF;
                        1:       taps_row = 48'h8000_8000_8000;
                        2:       taps_row = '0;
                        default: taps_row = ROWCOEF_W'({$urandom, $urandom});
                    endcase
                    coef_reg = (i == 0) ? REG_COEF_TOP :
                               (i == 1) ? REG_COEF_MIDDLE : REG_COEF_BOTTOM;
                    reg_write(coef_reg, pad_noise(DATA_W'(taps_row), ROWCOEF_W));
                end
            end

            // width always rewritten, so each phase starts a clean frame
            reg_write(REG_FRAME_WIDTH, pad_noise(DATA_W'(w_raw), GEOM_W));
            cur_w = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
            cur_h = (h_raw == 0) ? 1 : h_raw;

            for (int unsigned f = 0; f < frames; f++)
            begin
                run_frame(cut && (f == frames - 1));
            end
            settle();
            phase_no++;
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
